### rtl/rawe_pkg.sv
// ----------------------------------------------------------------------------
// rawe_pkg
// Shared widths, reset values and request payload types for the rebinning
// average block.
// ----------------------------------------------------------------------------
`default_nettype none

package rawe_pkg;

  // Field widths
  localparam int DATA_W        = 32;          // Q8.24 content
  localparam int ERR_W         = DATA_W - 1;  // Q7.24 error, nonnegative
  localparam int GIDX_W        = 8;           // output bin index
  localparam int GS_W          = 6;           // group size register
  localparam int GS_RESET      = 20;          // group size after reset
  localparam int MAX_GROUP_DEF = 32;          // default largest group

  // Squared-error accumulator and its root
  localparam int SQ_W   = 64;
  localparam int ROOT_W = SQ_W / 2;

  // Input request
  typedef struct packed {
    logic signed [DATA_W-1:0] bin_value;
    logic        [ERR_W-1:0]  bin_error;
    logic                     first_bin;
  } rawe_in_t;

  // Output request
  typedef struct packed {
    logic signed [DATA_W-1:0] mean_value;
    logic        [ERR_W-1:0]  mean_error;
    logic        [GIDX_W-1:0] group_index;
  } rawe_out_t;

endpackage

`default_nettype wire

### rtl/rebin_average_with_error_top.sv
// ----------------------------------------------------------------------------
// rebin_average_with_error_top
// Merges runs of histogram bins into one output bin: mean of the nonzero
// contents and quadrature error over the count, all bit-serial.
// ----------------------------------------------------------------------------
// One input request is taken at a time. A bin with zero content needs no
// serial square. A nonzero bin has its error squared by a bit-serial
// shift-and-add multiplier and added to the saturating squared sum. The bin
// that closes a group adds the result phase: a restoring divider for the
// mean, a digit-by-digit square root that takes two radicand bits and gives
// one root bit per step, the same divider again for the error and a load of
// the output register. A group with no nonzero bin skips the divider and
// root and loads its zero result directly. The output register parts the
// two sides, so a finished group may wait on a stalled output while the next
// bins are taken in; input stalls while any serial step runs and while a
// second result waits for the first to be taken. group_size is clamped to
// 1..MAX_GROUP on use.
`default_nettype none

module rebin_average_with_error_top #(
  parameter int unsigned MAX_GROUP = rawe_pkg::MAX_GROUP_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration
  input  wire logic                     cfg_we_i,
  input  wire logic [rawe_pkg::GS_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire rawe_pkg::rawe_in_t       in_data_i,
  // output channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output rawe_pkg::rawe_out_t           out_data_o
);

  import rawe_pkg::*;

  localparam int SW   = DATA_W + $clog2(MAX_GROUP) + 1;  // signed sum width
  localparam int DIVW = (SW > ROOT_W) ? SW : ROOT_W;     // divider dividend
  localparam int ITW  = $clog2(DIVW);                    // iteration counter
  localparam int CW   = $clog2(MAX_GROUP + 1);           // count / position
  localparam int PW   = 2 * ERR_W;                       // error square

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_MEAN,
    ST_SQRT,
    ST_DIV_ERR,
    ST_OUT
  } state_e;

  state_e state_q;

  // Accumulated run state
  logic [GS_W-1:0]      group_size_q;
  logic signed [SW-1:0] value_sum_q;
  logic [SQ_W-1:0]      sq_sum_q;
  logic [CW-1:0]        nz_cnt_q;
  logic [CW-1:0]        pos_q;
  logic [GIDX_W-1:0]    gcnt_q;
  logic                 end_q;

  // Serial datapath
  logic [ITW-1:0]       iter_q;
  logic [ERR_W-1:0]     mplier_q;
  logic [PW-1:0]        mcand_q;
  logic [PW-1:0]        prod_q;
  logic [DIVW-1:0]      dq_q;
  logic [CW-1:0]        rem_q;
  logic                 neg_q;
  logic [SQ_W-1:0]      rad_q;
  logic [ROOT_W+1:0]    srem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [DATA_W-1:0]    mean_q;
  logic [ERR_W-1:0]     err_q;

  // Output register
  logic                 out_valid_q;
  rawe_out_t            out_data_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Group size clamp and run bookkeeping for an incoming bin
  logic [GS_W:0]        gs_ext;
  logic [GS_W:0]        gs_clamp;
  logic [CW-1:0]        size_c;
  logic                 in_take;
  logic                 in_nz;
  logic [CW-1:0]        pos_next;
  logic [CW-1:0]        nz_base;
  logic signed [SW-1:0] vsum_base;

  always_comb begin
    gs_ext = {1'b0, group_size_q};
    if (gs_ext == '0) begin
      gs_clamp = (GS_W+1)'(1);
    end else if (gs_ext > (GS_W+1)'(MAX_GROUP)) begin
      gs_clamp = (GS_W+1)'(MAX_GROUP);
    end else begin
      gs_clamp = gs_ext;
    end
    size_c    = CW'(gs_clamp);
    in_take   = in_valid_i && (state_q == ST_IDLE);
    in_nz     = (in_data_i.bin_value != '0);
    pos_next  = (in_data_i.first_bin ? CW'(0) : pos_q) + CW'(1);
    nz_base   = in_data_i.first_bin ? CW'(0) : nz_cnt_q;
    vsum_base = in_data_i.first_bin ? SW'(0) : value_sum_q;
  end

  // Shift-and-add step of the error square
  logic [PW-1:0] prod_d;
  assign prod_d = prod_q + (mplier_q[0] ? mcand_q : PW'(0));

  // Saturating add of the square into the run sum
  logic [SQ_W:0]   sq_wide;
  logic [SQ_W-1:0] sq_sum_d;
  always_comb begin
    sq_wide  = {1'b0, sq_sum_q} + (SQ_W+1)'(prod_q);
    sq_sum_d = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
  end

  // Restoring divider step: one quotient bit per cycle, divisor is the count
  logic [CW:0]     rem_sh;
  logic            div_ge;
  logic [CW:0]     rem_sub;
  logic [CW-1:0]   rem_d;
  logic [DIVW-1:0] dq_d;
  always_comb begin
    rem_sh  = {rem_q, dq_q[DIVW-1]};
    div_ge  = (rem_sh >= {1'b0, nz_cnt_q});
    rem_sub = rem_sh - {1'b0, nz_cnt_q};
    rem_d   = div_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
    dq_d    = {dq_q[DIVW-2:0], div_ge};
  end

  // Square root step: two radicand bits in, one root bit out
  logic [ROOT_W+1:0] srem_sh;
  logic [ROOT_W+1:0] trial;
  logic              sq_ge;
  logic [ROOT_W+1:0] srem_d;
  logic [ROOT_W-1:0] root_d;
  always_comb begin
    srem_sh = {srem_q[ROOT_W-1:0], rad_q[SQ_W-1:SQ_W-2]};
    trial   = {root_q, 2'b01};
    sq_ge   = (srem_sh >= trial);
    srem_d  = sq_ge ? (srem_sh - trial) : srem_sh;
    root_d  = {root_q[ROOT_W-2:0], sq_ge};
  end

  // Magnitude of the content sum, for the mean division
  logic [SW-1:0] sum_mag;
  assign sum_mag = value_sum_q[SW-1] ? SW'(-value_sum_q) : SW'(value_sum_q);

  // Signed mean and clamped error from the finished quotient
  logic [DATA_W-1:0] mean_d;
  logic [ERR_W-1:0]  err_d;
  always_comb begin
    mean_d = neg_q ? (DATA_W'(0) - dq_d[DATA_W-1:0]) : dq_d[DATA_W-1:0];
    err_d  = ((dq_d >> ERR_W) != '0) ? '1 : dq_d[ERR_W-1:0];
  end

  // Sequencer, run state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      group_size_q <= GS_W'(GS_RESET);
      value_sum_q  <= '0;
      sq_sum_q     <= '0;
      nz_cnt_q     <= '0;
      pos_q        <= '0;
      gcnt_q       <= '0;
      end_q        <= 1'b0;
      iter_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        group_size_q <= cfg_wdata_i;
      end

      // taken result leaves the output register, unless a new one loads now
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            pos_q <= pos_next;
            end_q <= (pos_next >= size_c);
            if (in_data_i.first_bin) begin
              gcnt_q   <= '0;
              sq_sum_q <= '0;
            end
            if (in_nz) begin
              value_sum_q <= vsum_base + SW'(in_data_i.bin_value);
              nz_cnt_q    <= nz_base + CW'(1);
              mplier_q    <= in_data_i.bin_error;
              mcand_q     <= PW'(in_data_i.bin_error);
              prod_q      <= '0;
              iter_q      <= ITW'(ERR_W - 1);
              state_q     <= ST_MUL;
            end else begin
              value_sum_q <= vsum_base;
              nz_cnt_q    <= nz_base;
              if (pos_next >= size_c) begin
                if (nz_base == '0) begin
                  // empty group: zero result
                  mean_q  <= '0;
                  err_q   <= '0;
                  state_q <= ST_OUT;
                end else begin
                  dq_q    <= DIVW'(sum_mag);
                  neg_q   <= value_sum_q[SW-1];
                  rem_q   <= '0;
                  iter_q  <= ITW'(DIVW - 1);
                  state_q <= ST_DIV_MEAN;
                end
              end
            end
          end
        end

        ST_MUL: begin
          prod_q   <= prod_d;
          mcand_q  <= {mcand_q[PW-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[ERR_W-1:1]};
          iter_q   <= iter_q - ITW'(1);
          if (iter_q == '0) begin
            state_q <= ST_ACC;
          end
        end

        ST_ACC: begin
          sq_sum_q <= sq_sum_d;
          if (end_q) begin
            dq_q    <= DIVW'(sum_mag);
            neg_q   <= value_sum_q[SW-1];
            rem_q   <= '0;
            iter_q  <= ITW'(DIVW - 1);
            state_q <= ST_DIV_MEAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_DIV_MEAN: begin
          dq_q  <= dq_d;
          rem_q <= rem_d;
          if (iter_q == '0) begin
            mean_q  <= mean_d;
            rad_q   <= sq_sum_q;
            srem_q  <= '0;
            root_q  <= '0;
            iter_q  <= ITW'(ROOT_W - 1);
            state_q <= ST_SQRT;
          end else begin
            iter_q <= iter_q - ITW'(1);
          end
        end

        ST_SQRT: begin
          rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
          srem_q <= srem_d;
          root_q <= root_d;
          if (iter_q == '0) begin
            dq_q    <= DIVW'(root_d);
            neg_q   <= 1'b0;
            rem_q   <= '0;
            iter_q  <= ITW'(DIVW - 1);
            state_q <= ST_DIV_ERR;
          end else begin
            iter_q <= iter_q - ITW'(1);
          end
        end

        ST_DIV_ERR: begin
          dq_q   <= dq_d;
          rem_q  <= rem_d;
          iter_q <= iter_q - ITW'(1);
          if (iter_q == '0) begin
            err_q   <= err_d;
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          // wait for a free output register, then close the run
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q             <= 1'b1;
            out_data_q.mean_value   <= mean_q;
            out_data_q.mean_error   <= err_q;
            out_data_q.group_index  <= gcnt_q;
            gcnt_q                  <= gcnt_q + GIDX_W'(1);
            value_sum_q             <= '0;
            sq_sum_q                <= '0;
            nz_cnt_q                <= '0;
            pos_q                   <= '0;
            end_q                   <= 1'b0;
            state_q                 <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/rawe_checker.sv
// ----------------------------------------------------------------------------
// rawe_checker
// Port-level checks of the rebinning average block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rawe_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire rawe_pkg::rawe_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire rawe_pkg::rawe_out_t out_data_o
);

  // A stalled result request stays offered
  a_out_valid_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o
  ) else $error("result request dropped while stalled");

  // A stalled result request keeps its payload
  a_out_data_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)
  ) else $error("result payload changed while stalled");

  // A nonzero bin starts the serial square, so input stalls next cycle
  a_nz_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.bin_value != '0) |=> in_stall_o
  ) else $error("input not stalled while squaring the error");

  // A new result is only loaded by the result phase, never from idle
  a_out_from_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)
  ) else $error("result appeared without a result phase");

endmodule

bind rebin_average_with_error_top rawe_checker u_rawe_checker (.*);

`default_nettype wire
